/* rtl/core/crd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package crd_pkg;

    // Fixed-point formats
    localparam int COMP_W   = 16;            // signed Q1.14 component
    localparam int BASIS_W  = 3 * COMP_W;    // packed x,y,z triple
    localparam int Q88_W    = 16;            // unsigned Q8.8
    localparam int FRAC_SH  = 14;            // Q1.14 fraction bits
    localparam int MAG_W    = 48;            // exact component magnitude
    localparam int NORM_W   = 23;            // normalised magnitude, max in [2^22, 2^23)
    localparam int NORM_TOP = NORM_W - 1;    // target msb position
    localparam int POS_W    = 6;             // msb position of a MAG_W word
    localparam int SUMSQ_W  = 48;            // sum of three squares
    localparam int ROOT_W   = SUMSQ_W / 2;   // integer square root
    localparam int NUM_W    = NORM_W + FRAC_SH + 1;   // m*2^14 + r/2
    localparam int QUO_W    = FRAC_SH + 1;   // quotient bits
    localparam logic [QUO_W-1:0] ONE_Q14 = QUO_W'(1 << FRAC_SH);

    // Configuration register indices
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_FORWARD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_RIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_UP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_DIST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 3'd5;
    localparam logic [Q88_W-1:0] NEAR_DIST_RESET = 16'd256;

    typedef struct packed {
        logic signed [COMP_W-1:0] screen_x;
        logic signed [COMP_W-1:0] screen_y;
    } crd_req_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] ray_x;
        logic signed [COMP_W-1:0] ray_y;
        logic signed [COMP_W-1:0] ray_z;
        logic                     degenerate;
    } crd_res_t;

endpackage

`default_nettype wire

/* rtl/core/crd_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root, one result bit per stage, with a side
// band that travels alongside.
module crd_isqrt
    import crd_pkg::*;
#(
    parameter int SIDE_W = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [SUMSQ_W-1:0]   in_sum,
    input  wire logic [SIDE_W-1:0]    in_side,
    output logic                      out_valid,
    output logic [ROOT_W-1:0]         out_root,
    output logic [SIDE_W-1:0]         out_side
);

    localparam int W = SUMSQ_W + 1;

    logic [ROOT_W:0]     valid_reg;
    logic [W-1:0]        rem_reg  [ROOT_W+1];
    logic [W-1:0]        res_reg  [ROOT_W+1];
    logic [SIDE_W-1:0]   side_reg [ROOT_W+1];

    // Stage zero takes the operand as it comes
    always_comb
    begin
        valid_reg[0] = in_valid;
        rem_reg[0]   = W'(in_sum);
        res_reg[0]   = '0;
        side_reg[0]  = in_side;
    end

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_stage
        localparam logic [W-1:0] BIT = W'(1) << (SUMSQ_W - 2 - 2 * j);
        logic [W-1:0] trial;
        logic [W-1:0] rem_next;
        logic [W-1:0] res_next;

        // Try one root bit
        always_comb
        begin
            trial = res_reg[j] + BIT;
            if (rem_reg[j] >= trial)
            begin
                rem_next = rem_reg[j] - trial;
                res_next = (res_reg[j] >> 1) + BIT;
            end
            else
            begin
                rem_next = rem_reg[j];
                res_next = res_reg[j] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j+1] <= 1'b0;
            end
            else
            begin
                valid_reg[j+1] <= valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1]  <= rem_next;
            res_reg[j+1]  <= res_next;
            side_reg[j+1] <= side_reg[j];
        end
    end

    assign out_valid = valid_reg[ROOT_W];
    assign out_root  = res_reg[ROOT_W][ROOT_W-1:0];
    assign out_side  = side_reg[ROOT_W];

endmodule

`default_nettype wire

/* rtl/core/crd_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider for three numerators over one divisor,
// one quotient bit per stage.
module crd_div
    import crd_pkg::*;
#(
    parameter int SIDE_W = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [NUM_W-1:0]     in_num [3],
    input  wire logic [ROOT_W-1:0]    in_den,
    input  wire logic [SIDE_W-1:0]    in_side,
    output logic                      out_valid,
    output logic [QUO_W-1:0]          out_quo [3],
    output logic [SIDE_W-1:0]         out_side
);

    logic [QUO_W:0]      valid_reg;
    logic [NUM_W-1:0]    rem_reg  [QUO_W+1][3];
    logic [QUO_W-1:0]    quo_reg  [QUO_W+1][3];
    logic [ROOT_W-1:0]   den_reg  [QUO_W+1];
    logic [SIDE_W-1:0]   side_reg [QUO_W+1];

    always_comb
    begin
        valid_reg[0] = in_valid;
        den_reg[0]   = in_den;
        side_reg[0]  = in_side;
        for (int l = 0; l < 3; l++)
        begin
            rem_reg[0][l] = in_num[l];
            quo_reg[0][l] = '0;
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        localparam int SH = QUO_W - 1 - k;
        logic [NUM_W-1:0] dsh;

        assign dsh = NUM_W'(den_reg[k]) << SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        // Subtract the shifted divisor where it fits
        always_ff @(posedge clk)
        begin
            den_reg[k+1]  <= den_reg[k];
            side_reg[k+1] <= side_reg[k];
            for (int l = 0; l < 3; l++)
            begin
                if (rem_reg[k][l] >= dsh)
                begin
                    rem_reg[k+1][l] <= rem_reg[k][l] - dsh;
                    quo_reg[k+1][l] <= quo_reg[k][l] | (QUO_W'(1) << SH);
                end
                else
                begin
                    rem_reg[k+1][l] <= rem_reg[k][l];
                    quo_reg[k+1][l] <= quo_reg[k][l];
                end
            end
        end
    end

    assign out_valid = valid_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];
    for (genvar l = 0; l < 3; l++)
    begin : g_out
        assign out_quo[l] = quo_reg[QUO_W][l];
    end

endmodule

`default_nettype wire

/* rtl/core/camera_ray_direction.sv */
`timescale 1ns / 1ps
`default_nettype none

// Pinhole camera primary ray direction.
// Request channel: present a screen point on req with start high; it is
// taken at any edge where busy is low. busy never rises, so one request
// can enter every cycle.
// Result channel: done is high for one cycle while result holds the unit
// ray direction (signed Q1.14) and the degenerate flag. The receiver
// cannot hold results off; results leave in request order.
// Path: a request passes through 49 register stages (8 of products,
// sum and normalisation, 24 in the square root, one to form the
// numerators, 15 in the divider, one output register).
// Throughput: one request per cycle; every stage is a plain register.
// Configuration: write registers through cfg_valid/cfg_ready with
// cfg_index and cfg_data, only while no request is in flight.
// Reset clears the pipeline valid bits and loads the register reset
// values (near distance 1.0, all others zero).
module camera_ray_direction
    import crd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire crd_req_t              req,
    output logic                       done,
    output crd_res_t                   result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [BASIS_W-1:0]    cfg_data
);

    localparam int P1_W = 2 * COMP_W + 1;        // 16 x 17 signed product
    localparam int TF_W = P1_W + FRAC_SH;        // near term scaled by 2^14
    localparam int TR_W = P1_W + COMP_W;         // 33 x 16 signed product
    localparam int C_W  = TR_W + 2;              // three-term sum
    localparam int SQ_W = 2 * NORM_W;
    localparam int SIDE_SQRT_W = 3 * NORM_W + 4;

    logic [BASIS_W-1:0] fwd_reg, right_reg, up_reg;
    logic [Q88_W-1:0]   near_reg, hw_reg, hh_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg   <= '0;
            right_reg <= '0;
            up_reg    <= '0;
            near_reg  <= NEAR_DIST_RESET;
            hw_reg    <= '0;
            hh_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CAM_FORWARD: fwd_reg   <= cfg_data;
                REG_CAM_RIGHT:   right_reg <= cfg_data;
                REG_CAM_UP:      up_reg    <= cfg_data;
                REG_NEAR_DIST:   near_reg  <= cfg_data[Q88_W-1:0];
                REG_HALF_WIDTH:  hw_reg    <= cfg_data[Q88_W-1:0];
                REG_HALF_HEIGHT: hh_reg    <= cfg_data[Q88_W-1:0];
                default:         ;
            endcase
        end
    end

    logic signed [COMP_W-1:0] f_c [3], r_c [3], u_c [3];
    for (genvar i = 0; i < 3; i++)
    begin : g_basis
        assign f_c[i] = fwd_reg[COMP_W*i +: COMP_W];
        assign r_c[i] = right_reg[COMP_W*i +: COMP_W];
        assign u_c[i] = up_reg[COMP_W*i +: COMP_W];
    end

    // Valid bits for stages one to eight
    logic [8:1] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[7:1], start & ~busy};
        end
    end

    // Stage 1: scale screen point and forward vector
    logic signed [P1_W-1:0] kx_reg, ky_reg, nf_reg [3];
    always_ff @(posedge clk)
    begin
        kx_reg <= req.screen_x * $signed({1'b0, hw_reg});
        ky_reg <= req.screen_y * $signed({1'b0, hh_reg});
        for (int i = 0; i < 3; i++)
        begin
            nf_reg[i] <= $signed({1'b0, near_reg}) * f_c[i];
        end
    end

    // Stage 2: basis products
    logic signed [TF_W-1:0] tf_reg [3];
    logic signed [TR_W-1:0] tr_reg [3], tu_reg [3];
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            tf_reg[i] <= {nf_reg[i], {FRAC_SH{1'b0}}};
            tr_reg[i] <= kx_reg * r_c[i];
            tu_reg[i] <= ky_reg * u_c[i];
        end
    end

    // Stage 3: exact sum, split into sign and magnitude
    logic signed [C_W-1:0] csum [3];
    logic [C_W-1:0]        cabs [3];
    logic [MAG_W-1:0]      mag3_reg [3];
    logic [2:0]            neg3_reg;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            csum[i] = C_W'(tf_reg[i]) - C_W'(tr_reg[i]) - C_W'(tu_reg[i]);
            cabs[i] = csum[i][C_W-1] ? C_W'(-csum[i]) : C_W'(csum[i]);
        end
    end
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag3_reg[i] <= cabs[i][MAG_W-1:0];
            neg3_reg[i] <= csum[i][C_W-1];
        end
    end

    // Stage 4: largest magnitude
    logic [MAG_W-1:0] max01, max_next;
    logic [MAG_W-1:0] mag4_reg [3];
    logic [MAG_W-1:0] max4_reg;
    logic [2:0]       neg4_reg;
    always_comb
    begin
        max01    = (mag3_reg[0] > mag3_reg[1]) ? mag3_reg[0] : mag3_reg[1];
        max_next = (max01 > mag3_reg[2]) ? max01 : mag3_reg[2];
    end
    always_ff @(posedge clk)
    begin
        mag4_reg <= mag3_reg;
        max4_reg <= max_next;
        neg4_reg <= neg3_reg;
    end

    // Stage 5: leading one of the largest magnitude
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] pos5_reg;
    logic             deg5_reg;
    logic [MAG_W-1:0] mag5_reg [3];
    logic [2:0]       neg5_reg;
    always_comb
    begin
        pos_next = '0;
        for (int b = 0; b < MAG_W; b++)
        begin
            if (max4_reg[b])
            begin
                pos_next = POS_W'(b);
            end
        end
    end
    always_ff @(posedge clk)
    begin
        pos5_reg <= pos_next;
        deg5_reg <= (max4_reg == '0);
        mag5_reg <= mag4_reg;
        neg5_reg <= neg4_reg;
    end

    // Stage 6: bring the largest into [2^22, 2^23)
    logic [NORM_W-1:0] norm_next [3];
    logic [NORM_W-1:0] mag6_reg [3];
    logic [2:0]        neg6_reg;
    logic              deg6_reg;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (pos5_reg >= POS_W'(NORM_TOP))
            begin
                norm_next[i] = NORM_W'(mag5_reg[i] >> (pos5_reg - POS_W'(NORM_TOP)));
            end
            else
            begin
                norm_next[i] = mag5_reg[i][NORM_W-1:0] << (POS_W'(NORM_TOP) - pos5_reg);
            end
        end
    end
    always_ff @(posedge clk)
    begin
        mag6_reg <= norm_next;
        neg6_reg <= neg5_reg;
        deg6_reg <= deg5_reg;
    end

    // Stage 7: squares
    logic [SQ_W-1:0]   sq7_reg [3];
    logic [NORM_W-1:0] mag7_reg [3];
    logic [2:0]        neg7_reg;
    logic              deg7_reg;
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq7_reg[i] <= mag6_reg[i] * mag6_reg[i];
        end
        mag7_reg <= mag6_reg;
        neg7_reg <= neg6_reg;
        deg7_reg <= deg6_reg;
    end

    // Stage 8: sum of squares
    logic [SUMSQ_W-1:0] sum8_reg;
    logic [SIDE_SQRT_W-1:0] side8_reg;
    always_ff @(posedge clk)
    begin
        sum8_reg  <= SUMSQ_W'(sq7_reg[0]) + SUMSQ_W'(sq7_reg[1])
                   + SUMSQ_W'(sq7_reg[2]);
        side8_reg <= {mag7_reg[0], mag7_reg[1], mag7_reg[2], neg7_reg, deg7_reg};
    end

    // Square root of the sum
    logic                   sq_valid;
    logic [ROOT_W-1:0]      root;
    logic [SIDE_SQRT_W-1:0] sq_side;

    crd_isqrt #(
        .SIDE_W (SIDE_SQRT_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[8]),
        .in_sum    (sum8_reg),
        .in_side   (side8_reg),
        .out_valid (sq_valid),
        .out_root  (root),
        .out_side  (sq_side)
    );

    // Rounded numerators m*2^14 + r/2
    logic [NORM_W-1:0] sq_mag [3];
    assign sq_mag[0] = sq_side[SIDE_SQRT_W-1 -: NORM_W];
    assign sq_mag[1] = sq_side[SIDE_SQRT_W-1-NORM_W -: NORM_W];
    assign sq_mag[2] = sq_side[SIDE_SQRT_W-1-2*NORM_W -: NORM_W];

    logic              num_valid_reg;
    logic [NUM_W-1:0]  num_reg [3];
    logic [ROOT_W-1:0] den_reg;
    logic [3:0]        nside_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_valid_reg <= 1'b0;
        end
        else
        begin
            num_valid_reg <= sq_valid;
        end
    end
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_reg[i] <= {1'b0, sq_mag[i], {FRAC_SH{1'b0}}} + NUM_W'(root >> 1);
        end
        den_reg   <= root;
        nside_reg <= sq_side[3:0];
    end

    // Divide by the root
    logic             div_valid;
    logic [QUO_W-1:0] quo [3];
    logic [3:0]       div_side;

    crd_div #(
        .SIDE_W (4)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (num_valid_reg),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .in_side   (nside_reg),
        .out_valid (div_valid),
        .out_quo   (quo),
        .out_side  (div_side)
    );

    // Cap, apply signs, drop to zero for a zero-length vector
    logic [QUO_W-1:0]         capped [3];
    logic signed [COMP_W-1:0] comp_next [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            capped[i] = (quo[i] > ONE_Q14) ? ONE_Q14 : quo[i];
            if (div_side[0])
            begin
                comp_next[i] = '0;
            end
            else if (div_side[i+1])
            begin
                comp_next[i] = -$signed(COMP_W'(capped[i]));
            end
            else
            begin
                comp_next[i] = $signed(COMP_W'(capped[i]));
            end
        end
    end

    crd_res_t result_reg;
    logic     done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end
    always_ff @(posedge clk)
    begin
        result_reg.ray_x      <= comp_next[0];
        result_reg.ray_y      <= comp_next[1];
        result_reg.ray_z      <= comp_next[2];
        result_reg.degenerate <= div_side[0];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import crd_pkg::*;

    localparam int LATENCY   = 49;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 1800;
    localparam int N_PHASES  = 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    crd_req_t req = '0;
    logic done;
    crd_res_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BASIS_W-1:0] cfg_data = '0;

    // Camera settings held by the predictor
    logic [BASIS_W-1:0] fwd_vec, right_vec, up_vec;
    logic [Q88_W-1:0] near_q, hw_q, hh_q;

    crd_res_t ray_queue[$];
    int mismatches = 0;
    int idle_pct = 38;
    int wdog = 0;
    bit timed_out = 0;

    camera_ray_direction dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] root64(input logic [63:0] s);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0)
        begin
            if (s >= res + b)
            begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic crd_res_t predict_ray(input crd_req_t p);
        longint sx, sy, kx, ky, c;
        longint unsigned mag[3];
        bit neg[3];
        longint unsigned maxm, s, r, q;
        int rsh, lsh;
        crd_res_t o;
        logic signed [15:0] outc[3];
        sx = p.screen_x;
        sy = p.screen_y;
        kx = sx * longint'(hw_q);
        ky = sy * longint'(hh_q);
        maxm = 0;
        o = '0;
        for (int i = 0; i < 3; i++)
        begin
            c = longint'(near_q) * longint'($signed(fwd_vec[16*i +: 16])) * 16384
              - kx * longint'($signed(right_vec[16*i +: 16]))
              - ky * longint'($signed(up_vec[16*i +: 16]));
            neg[i] = c < 0;
            mag[i] = neg[i] ? -c : c;
            if (mag[i] > maxm) maxm = mag[i];
        end
        if (maxm == 0)
        begin
            o.degenerate = 1'b1;
            return o;
        end
        rsh = 0;
        lsh = 0;
        while ((maxm >> rsh) >= (64'd1 << 23)) rsh++;
        while ((maxm << lsh) < (64'd1 << 22)) lsh++;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (mag[i] >> rsh) << lsh;
            s += mag[i] * mag[i];
        end
        r = root64(s);
        for (int i = 0; i < 3; i++)
        begin
            q = (r != 0) ? (mag[i] * 16384 + (r >> 1)) / r : 0;
            if (q > 16384) q = 16384;
            outc[i] = neg[i] ? -16'(q) : 16'(q);
        end
        o.ray_x = outc[0];
        o.ray_y = outc[1];
        o.ray_z = outc[2];
        return o;
    endfunction

    function automatic void store_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [BASIS_W-1:0] val);
        case (idx)
            REG_CAM_FORWARD: fwd_vec = val;
            REG_CAM_RIGHT:   right_vec = val;
            REG_CAM_UP:      up_vec = val;
            REG_NEAR_DIST:   near_q = val[15:0];
            REG_HALF_WIDTH:  hw_q = val[15:0];
            REG_HALF_HEIGHT: hh_q = val[15:0];
            default: ;
        endcase
    endfunction

    // Write one register, mirroring it in the predictor
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [BASIS_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        store_setting(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Send one request; the expectation is queued when it is taken
    task automatic send_point(input crd_req_t p, input bit typed,
                              input crd_res_t typed_res);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= p;
        @(posedge clk);
        while (busy) @(posedge clk);
        ray_queue.push_back(typed ? typed_res : predict_ray(p));
    endtask

    task automatic drain;
        start <= 1'b0;
        while (ray_queue.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [15:0] rnd_comp;
        case ($urandom_range(7))
            0: return 16'h4000;
            1: return 16'hC000;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'h0000;
            default: return 16'($urandom_range(32768)) - 16'd16384;
        endcase
    endfunction

    function automatic logic [15:0] rnd_point;
        if ($urandom_range(19) == 0) return 16'($urandom);
        return rnd_comp();
    endfunction

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (ray_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                crd_res_t e;
                e = ray_queue.pop_front();
                if (e.ray_x !== result.ray_x || e.ray_y !== result.ray_y ||
                    e.ray_z !== result.ray_z || e.degenerate !== result.degenerate)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ray mismatch: exp %h act %h", e, result);
                end
            end
        end
    end

    // Watchdog on cycles with no request, result or write taken
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX)
        begin
            $display("** camera_ray_direction: FAILED **");
            $finish;
        end
    end

    typedef struct {
        logic [15:0] sx;
        logic [15:0] sy;
        bit typed;
        crd_res_t res;
    } point_row_t;

    initial
    begin
        point_row_t rows[$];
        crd_res_t none;
        crd_req_t p;
        none = '0;
        fwd_vec = '0;
        right_vec = '0;
        up_vec = '0;
        near_q = NEAR_DIST_RESET;
        hw_q = '0;
        hh_q = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset all bases are zero: every point is degenerate
        rows.push_back('{16'h0000, 16'h0000, 1, crd_res_t'{0, 0, 0, 1'b1}});
        rows.push_back('{16'h4000, 16'hC000, 1, crd_res_t'{0, 0, 0, 1'b1}});
        foreach (rows[i])
        begin
            p.screen_x = rows[i].sx;
            p.screen_y = rows[i].sy;
            send_point(p, rows[i].typed, rows[i].res);
        end
        drain();

        // Axis-aligned camera: forward +z, right +x, up +y
        write_setting(REG_CAM_FORWARD, {16'h4000, 16'h0000, 16'h0000});
        write_setting(REG_CAM_RIGHT, {16'h0000, 16'h0000, 16'h4000});
        write_setting(REG_CAM_UP, {16'h0000, 16'h4000, 16'h0000});
        write_setting(REG_NEAR_DIST, 48'h0100);
        write_setting(REG_HALF_WIDTH, 48'h0100);
        write_setting(REG_HALF_HEIGHT, 48'h0100);
        write_setting(3'd7, 48'hFFFF_FFFF_FFFF);
        rows.delete();
        rows.push_back('{16'h0000, 16'h0000, 1, crd_res_t'{0, 0, 16'sh4000, 1'b0}});
        rows.push_back('{16'h4000, 16'h0000, 0, none});
        rows.push_back('{16'hC000, 16'h0000, 0, none});
        rows.push_back('{16'h0000, 16'h4000, 0, none});
        rows.push_back('{16'h0000, 16'hC000, 0, none});
        rows.push_back('{16'h4000, 16'h4000, 0, none});
        rows.push_back('{16'hC000, 16'hC000, 0, none});
        rows.push_back('{16'h8000, 16'h8000, 0, none});
        rows.push_back('{16'h7FFF, 16'h8000, 0, none});
        rows.push_back('{16'hFFFF, 16'h0001, 0, none});
        foreach (rows[i])
        begin
            p.screen_x = rows[i].sx;
            p.screen_y = rows[i].sy;
            send_point(p, rows[i].typed, rows[i].res);
        end
        drain();

        // Zero near distance: the centre point has zero length
        write_setting(REG_NEAR_DIST, 48'h0);
        p = '0;
        send_point(p, 1, crd_res_t'{0, 0, 0, 1'b1});
        p.screen_x = 16'sh4000;
        send_point(p, 0, none);
        drain();

        // Extremes of every register, wide data bits dropped
        write_setting(REG_NEAR_DIST, 48'hFFFF_FFFF_FFFF);
        write_setting(REG_HALF_WIDTH, 48'hFFFF_FFFF_FFFF);
        write_setting(REG_HALF_HEIGHT, 48'hABCD_0000_FFFF);
        write_setting(REG_CAM_FORWARD, {16'h8000, 16'h8000, 16'h8000});
        write_setting(REG_CAM_RIGHT, {16'h7FFF, 16'h8000, 16'h7FFF});
        write_setting(REG_CAM_UP, 48'hFFFF_FFFF_FFFF);
        for (int i = 0; i < 6; i++)
        begin
            p.screen_x = rnd_point();
            p.screen_y = rnd_point();
            send_point(p, 0, none);
        end
        drain();

        // Random phases with new settings between them
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            write_setting(REG_CAM_FORWARD, {rnd_comp(), rnd_comp(), rnd_comp()});
            write_setting(REG_CAM_RIGHT, {rnd_comp(), rnd_comp(), rnd_comp()});
            write_setting(REG_CAM_UP, {rnd_comp(), rnd_comp(), rnd_comp()});
            write_setting(REG_NEAR_DIST, ph == 1 ? 48'h0 : 48'($urandom_range(65535)));
            write_setting(REG_HALF_WIDTH, ph == 2 ? 48'hFFFF : 48'($urandom_range(1023)));
            write_setting(REG_HALF_HEIGHT, ph == 3 ? 48'h0 : 48'($urandom_range(65535)));
            idle_pct = (ph == 2) ? 0 : 38;
            for (int i = 0; i < N_RANDOM / N_PHASES; i++)
            begin
                p.screen_x = rnd_point();
                p.screen_y = rnd_point();
                send_point(p, 0, none);
            end
            drain();
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && ray_queue.size() == 0)
            $display("** camera_ray_direction: PASSED **");
        else
            $display("** camera_ray_direction: FAILED **");
        $finish;
    end

    // Drive cfg_valid idle at time zero
    initial
    begin
        cfg_valid = 1'b0;
    end
endmodule
